>>> rtl/fpdt_pkg.sv
// ----------------------------------------------------------------------------
// fpdt_pkg
// shared types and constants of the fixed-point to decimal text block
// ----------------------------------------------------------------------------
package fpdt_pkg;

    localparam int CHAR_W      = 7;
    localparam int CFG_W       = 5;
    localparam int DIGIT_CAP   = 16;
    localparam int DIGIT_IDX_W = 4;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd4;
    localparam logic [CFG_W-1:0] LIMIT_CAP   = 5'd16;

    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_FRAC,
        ST_SKIP,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FDIG
    } t_state;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] character;
    } t_emit;

endpackage

>>> rtl/fpdt_dabble.sv
// ----------------------------------------------------------------------------
// fpdt_dabble
// one shift-and-add-3 step of binary to bcd conversion
// ----------------------------------------------------------------------------
module fpdt_dabble #(
    parameter int NUM_DIGITS = 5,
    parameter int BIN_W      = 16
) (
    input  logic [NUM_DIGITS-1:0][3:0] i_bcd,
    input  logic [BIN_W-1:0]           i_bin,
    output logic [NUM_DIGITS-1:0][3:0] o_bcd,
    output logic [BIN_W-1:0]           o_bin
);

    logic [NUM_DIGITS-1:0][3:0] adj;
    logic [4*NUM_DIGITS-1:0]    adj_flat;

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            adj[d] = (i_bcd[d] >= 4'd5) ? (i_bcd[d] + 4'd3) : i_bcd[d];
        end
    end

    assign adj_flat = adj;

    // shift the adjusted digits left, binary msb enters at the bottom
    assign o_bcd = {adj_flat[4*NUM_DIGITS-2:0], i_bin[BIN_W-1]};
    assign o_bin = i_bin << 1;

endmodule

>>> rtl/fpdt_times10.sv
// ----------------------------------------------------------------------------
// fpdt_times10
// one fraction digit: remainder times ten, split into digit and new remainder
// ----------------------------------------------------------------------------
module fpdt_times10 #(
    parameter int FRAC_W = 16
) (
    input  logic [FRAC_W-1:0] i_rem,
    output logic [3:0]        o_digit,
    output logic [FRAC_W-1:0] o_rem
);

    logic [FRAC_W+3:0] prod;

    // x*10 as x*8 + x*2
    assign prod    = (FRAC_W+4)'({i_rem, 3'b000}) + (FRAC_W+4)'({i_rem, 1'b0});
    assign o_digit = prod[FRAC_W+3:FRAC_W];
    assign o_rem   = prod[FRAC_W-1:0];

endmodule

>>> rtl/fpdt_outreg.sv
// ----------------------------------------------------------------------------
// fpdt_outreg
// output register of the character channel
// ----------------------------------------------------------------------------
module fpdt_outreg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpdt_pkg::t_emit             i_emit,
    input  logic                        i_stall,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [fpdt_pkg::CHAR_W-1:0] o_character,
    output logic                        o_last_char
);

    logic                        r_valid;
    logic [fpdt_pkg::CHAR_W-1:0] r_character;
    logic                        r_last_char;

    // empty, or the held character leaves at this edge
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_emit.valid) begin
            r_character <= i_emit.character;
            r_last_char <= i_emit.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_character;
    assign o_last_char = r_last_char;

endmodule

>>> rtl/fixed_point_to_decimal_text_top.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_text_top
// signed fixed-point value in, decimal ascii text out, one character a transfer
// ----------------------------------------------------------------------------
// One value is taken per transfer on the input channel and its text leaves one
// character per transfer: an optional '-', the integer digits ('0' for a zero
// integer part), and, for a nonzero fraction, '.' and up to max_fraction_digits
// fraction digits (values above 16 act as 16), with one trailing '0' removed
// when two or more digits were made. o_last_char marks the final character.
// The block takes one value at a time and holds o_in_stall high until the last
// character has been loaded into the output register. A value is worked in
// turn: the integer part of width WORD_BITS - FRACTION_BITS (at least 1) goes
// through the shared binary-to-bcd shift unit, the fraction digits are made by
// the shared times-ten unit, the leading zero bcd digits are skipped, and then
// the characters are sent.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_text_top #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  logic [fpdt_pkg::CFG_W-1:0]   i_cfg_wr_data,
    // value channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [WORD_BITS-1:0]  i_value,
    // character channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fpdt_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_last_char
);

    localparam int INT_W  = WORD_BITS - FRACTION_BITS;
    localparam int IWE    = (INT_W > 0) ? INT_W : 1;
    // decimal digits of the widest integer part, about IWE * log10(2)
    localparam int ND     = ((IWE * 1233) >> 12) + 1;
    localparam int IDX_W  = (ND > 1) ? $clog2(ND) : 1;
    localparam int CNT_W  = (IWE > 1) ? $clog2(IWE) : 1;
    localparam int EXT_W  = WORD_BITS + FRACTION_BITS;

    localparam int DIW = fpdt_pkg::DIGIT_IDX_W;
    localparam int CW  = fpdt_pkg::CFG_W;

    // state
    fpdt_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cfg;

    // datapath registers
    logic                                 r_neg, n_neg;
    logic                                 r_has_frac, n_has_frac;
    logic [IWE-1:0]                       r_bin, n_bin;
    logic [ND-1:0][3:0]                   r_bcd, n_bcd;
    logic [CNT_W-1:0]                     r_cnt, n_cnt;
    logic [FRACTION_BITS-1:0]             r_rem, n_rem;
    logic [CW-1:0]                        r_fcnt, n_fcnt;
    logic [3:0]                           r_last_dig, n_last_dig;
    logic [fpdt_pkg::DIGIT_CAP-1:0][3:0]  r_fbuf, n_fbuf;
    logic [IDX_W-1:0]                     r_idx, n_idx;
    logic [DIW-1:0]                       r_fidx, n_fidx;

    // input side
    logic                     in_accept;
    logic [WORD_BITS-1:0]     raw;
    logic [WORD_BITS-1:0]     mag_in;
    logic [EXT_W-1:0]         mag_ext;
    logic [IWE-1:0]           ip_in;
    logic [FRACTION_BITS-1:0] frac_in;

    // shared units
    logic [ND-1:0][3:0]       dab_bcd;
    logic [IWE-1:0]           dab_bin;
    logic [3:0]               t10_digit;
    logic [FRACTION_BITS-1:0] t10_rem;

    // sequencing terms
    logic [CW-1:0]    limit;
    logic [CW-1:0]    fcnt_m1;
    logic             gen_more;
    logic             drop_zero;
    logic [3:0]       int_digit;
    logic [3:0]       frac_digit;
    logic             out_free;
    fpdt_pkg::t_emit  emit;

    // ---- input decode: magnitude, integer part, fraction part ----
    assign in_accept = i_in_valid && !o_in_stall;
    assign raw       = i_value;
    // the most negative value negates to itself, read as unsigned it is right
    assign mag_in    = raw[WORD_BITS-1] ? ((~raw) + WORD_BITS'(1)) : raw;
    assign mag_ext   = EXT_W'(mag_in);
    assign frac_in   = mag_ext[FRACTION_BITS-1:0];
    assign ip_in     = IWE'(mag_in >> FRACTION_BITS);

    // ---- shared step units ----
    fpdt_dabble #(
        .NUM_DIGITS (ND),
        .BIN_W      (IWE)
    ) u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (dab_bcd),
        .o_bin (dab_bin)
    );

    fpdt_times10 #(
        .FRAC_W (FRACTION_BITS)
    ) u_times10 (
        .i_rem   (r_rem),
        .o_digit (t10_digit),
        .o_rem   (t10_rem)
    );

    // ---- sequencing terms ----
    assign limit      = (r_cfg > fpdt_pkg::LIMIT_CAP) ? fpdt_pkg::LIMIT_CAP : r_cfg;
    assign gen_more   = (r_rem != '0) && (r_fcnt < limit);
    assign fcnt_m1    = r_fcnt - CW'(1);
    // one trailing zero goes when at least two digits were made
    assign drop_zero  = (r_fcnt > CW'(1)) && (r_last_dig == 4'd0);
    assign int_digit  = r_bcd[r_idx];
    assign frac_digit = r_fbuf[r_fidx];

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpdt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = fpdt_pkg::ST_DABBLE;
                end
            end
            fpdt_pkg::ST_DABBLE: begin
                if (r_cnt == CNT_W'(IWE - 1)) begin
                    n_state = fpdt_pkg::ST_FRAC;
                end
            end
            fpdt_pkg::ST_FRAC: begin
                if (!gen_more) begin
                    n_state = fpdt_pkg::ST_SKIP;
                end
            end
            fpdt_pkg::ST_SKIP: begin
                if ((r_idx == '0) || (int_digit != 4'd0)) begin
                    n_state = r_neg ? fpdt_pkg::ST_SIGN : fpdt_pkg::ST_INT;
                end
            end
            fpdt_pkg::ST_SIGN: begin
                if (out_free) begin
                    n_state = fpdt_pkg::ST_INT;
                end
            end
            fpdt_pkg::ST_INT: begin
                if (out_free && (r_idx == '0)) begin
                    n_state = r_has_frac ? fpdt_pkg::ST_POINT : fpdt_pkg::ST_IDLE;
                end
            end
            fpdt_pkg::ST_POINT: begin
                if (out_free) begin
                    n_state = (r_fcnt == '0) ? fpdt_pkg::ST_IDLE : fpdt_pkg::ST_FDIG;
                end
            end
            fpdt_pkg::ST_FDIG: begin
                if (out_free && (CW'(r_fidx) == fcnt_m1)) begin
                    n_state = fpdt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpdt_pkg::ST_IDLE;
            end
        endcase
    end

    // ---- outputs of the sequencer ----
    always_comb begin
        emit       = '0;
        o_in_stall = 1'b1;
        case (r_state)
            fpdt_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            fpdt_pkg::ST_SIGN: begin
                emit.valid     = 1'b1;
                emit.character = fpdt_pkg::CH_MINUS;
            end
            fpdt_pkg::ST_INT: begin
                emit.valid     = 1'b1;
                emit.character = fpdt_pkg::CH_ZERO + {3'b000, int_digit};
                emit.last      = (r_idx == '0) && !r_has_frac;
            end
            fpdt_pkg::ST_POINT: begin
                emit.valid     = 1'b1;
                emit.character = fpdt_pkg::CH_POINT;
                // a zero digit limit ends the text at the point
                emit.last      = (r_fcnt == '0);
            end
            fpdt_pkg::ST_FDIG: begin
                emit.valid     = 1'b1;
                emit.character = fpdt_pkg::CH_ZERO + {3'b000, frac_digit};
                emit.last      = (CW'(r_fidx) == fcnt_m1);
            end
            default: begin
                emit = '0;
            end
        endcase
    end

    // ---- datapath next values ----
    always_comb begin
        n_neg      = r_neg;
        n_has_frac = r_has_frac;
        n_bin      = r_bin;
        n_bcd      = r_bcd;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_fcnt     = r_fcnt;
        n_last_dig = r_last_dig;
        n_fbuf     = r_fbuf;
        n_idx      = r_idx;
        n_fidx     = r_fidx;
        case (r_state)
            fpdt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_neg      = raw[WORD_BITS-1];
                    n_has_frac = (frac_in != '0);
                    n_bin      = ip_in;
                    n_bcd      = '0;
                    n_cnt      = '0;
                    n_rem      = frac_in;
                    n_fcnt     = '0;
                    n_idx      = IDX_W'(ND - 1);
                    n_fidx     = '0;
                end
            end
            fpdt_pkg::ST_DABBLE: begin
                n_bcd = dab_bcd;
                n_bin = dab_bin;
                n_cnt = r_cnt + CNT_W'(1);
            end
            fpdt_pkg::ST_FRAC: begin
                if (gen_more) begin
                    n_fbuf[r_fcnt[DIW-1:0]] = t10_digit;
                    n_last_dig              = t10_digit;
                    n_rem                   = t10_rem;
                    n_fcnt                  = r_fcnt + CW'(1);
                end else if (drop_zero) begin
                    n_fcnt = fcnt_m1;
                end
            end
            fpdt_pkg::ST_SKIP: begin
                // step down past leading zero digits
                if ((r_idx != '0) && (int_digit == 4'd0)) begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            fpdt_pkg::ST_INT: begin
                if (out_free && (r_idx != '0)) begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            fpdt_pkg::ST_FDIG: begin
                if (out_free) begin
                    n_fidx = r_fidx + DIW'(1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpdt_pkg::ST_IDLE;
            r_cfg   <= fpdt_pkg::LIMIT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_has_frac <= n_has_frac;
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_rem      <= n_rem;
        r_fcnt     <= n_fcnt;
        r_last_dig <= n_last_dig;
        r_fbuf     <= n_fbuf;
        r_idx      <= n_idx;
        r_fidx     <= n_fidx;
    end

    // ---- output register ----
    fpdt_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .i_stall     (i_out_stall),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule

>>> rtl/fpdt_checker.sv
// ----------------------------------------------------------------------------
// fpdt_checker
// port-level checks of the fixed-point to decimal text block
// ----------------------------------------------------------------------------
module fpdt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [fpdt_pkg::CHAR_W-1:0] o_character,
    input logic                        o_last_char
);

    // a transfer in starts work, so the next value must wait
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_character) && $stable(o_last_char)))
        else $error("stalled character changed");

    // only sign, point or digit codes leave
    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_character == fpdt_pkg::CH_MINUS) ||
                         (o_character == fpdt_pkg::CH_POINT) ||
                         ((o_character >= fpdt_pkg::CH_ZERO) &&
                          (o_character <= fpdt_pkg::CH_NINE))))
        else $error("character outside the text alphabet");

    // while a text is unfinished no new value is taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_char) |-> o_in_stall)
        else $error("new value taken before the text ended");

endmodule

bind fixed_point_to_decimal_text_top fpdt_checker u_fpdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_character (o_character),
    .o_last_char (o_last_char)
);
